// ----- design/tdq_pkg.sv -----
// Shared types and constants for the task dispatch queue.
// Holds command and status codes, the sequencer states and the ring control structs.
// Has no dependencies.
package tdq_pkg;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int REF_W    = 32;
  localparam int TID_W    = 16;
  localparam int ACT_W    = 7;

  localparam logic [ACT_W-1:0] MAX_ACTIVE_RESET = 7'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_SUBMIT   = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_COMPLETE = 2'd2,
    CMD_FETCH    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_QUEUE_FULL   = 3'd1,
    ST_QUEUE_EMPTY  = 3'd2,
    ST_SLOTS_BUSY   = 3'd3,
    ST_NOT_FOUND    = 3'd4,
    ST_RESULTS_FULL = 3'd5,
    ST_NO_ACTIVE    = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_FRD,
    S_FCMP,
    S_SHRD,
    S_SHWR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ring_stat_t;

endpackage

// ----- design/tdq_if.sv -----
// Valid/ready channel interfaces for commands and responses.
// Depends on tdq_pkg for field widths.
interface tdq_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [tdq_pkg::CMD_W-1:0]   command;
  logic [tdq_pkg::REF_W-1:0]   function_ref;
  logic [tdq_pkg::REF_W-1:0]   argument_ref;
  logic [tdq_pkg::TID_W-1:0]   task_id;
  logic [tdq_pkg::REF_W-1:0]   result_value;

  modport source (output valid, command, function_ref, argument_ref, task_id, result_value,
                  input ready);
  modport sink (input valid, command, function_ref, argument_ref, task_id, result_value,
                output ready);
endinterface

interface tdq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [tdq_pkg::STATUS_W-1:0] status;
  logic [tdq_pkg::TID_W-1:0]    out_task_id;
  logic [tdq_pkg::REF_W-1:0]    out_function_ref;
  logic [tdq_pkg::REF_W-1:0]    out_argument_ref;
  logic [tdq_pkg::REF_W-1:0]    out_result_value;
  logic [tdq_pkg::ACT_W-1:0]    active_now;

  modport source (output valid, status, out_task_id, out_function_ref, out_argument_ref,
                  out_result_value, active_now, input ready);
  modport sink (input valid, status, out_task_id, out_function_ref, out_argument_ref,
                out_result_value, active_now, output ready);
endinterface

// ----- design/tdq_task_ring.sv -----
// Ring queue of pending tasks: one memory, head/tail pointers and a fill count.
// Depends on tdq_pkg for the control structs.
module tdq_task_ring #(
  parameter int QUEUE_DEPTH = 256,
  parameter int ID_WIDTH    = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tdq_pkg::ring_ctrl_t       ctrl,
  output tdq_pkg::ring_stat_t       stat,
  input  logic [tdq_pkg::REF_W-1:0] wr_fref,
  input  logic [tdq_pkg::REF_W-1:0] wr_aref,
  input  logic [ID_WIDTH-1:0]       wr_id,
  output logic [tdq_pkg::REF_W-1:0] rd_fref,
  output logic [tdq_pkg::REF_W-1:0] rd_aref,
  output logic [ID_WIDTH-1:0]       rd_id
);
  import tdq_pkg::*;

  localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QF_W = $clog2(QUEUE_DEPTH + 1);
  localparam int EW   = ID_WIDTH + 2 * REF_W;

  logic [EW-1:0]   mem [QUEUE_DEPTH];
  logic [EW-1:0]   rd_data;
  logic [QA_W-1:0] head;
  logic [QA_W-1:0] tail;
  logic [QF_W-1:0] fill;

  assign stat.full  = (fill == QF_W'(QUEUE_DEPTH));
  assign stat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (ctrl.push) begin
        tail <= (tail == QA_W'(QUEUE_DEPTH - 1)) ? '0 : tail + QA_W'(1);
      end
      if (ctrl.pop) begin
        head <= (head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head + QA_W'(1);
      end
      if (ctrl.push && !ctrl.pop) begin
        fill <= fill + QF_W'(1);
      end else if (ctrl.pop && !ctrl.push) begin
        fill <= fill - QF_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[tail] <= {wr_id, wr_fref, wr_aref};
    end
    if (ctrl.pop) begin
      rd_data <= mem[head];
    end
  end

  assign rd_id   = rd_data[EW-1 -: ID_WIDTH];
  assign rd_fref = rd_data[2*REF_W-1 -: REF_W];
  assign rd_aref = rd_data[REF_W-1:0];

endmodule

// ----- design/task_dispatch_queue_with_result_table.sv -----
// Task dispatch queue with a concurrency limit and a result table (top level).
// Depends on tdq_pkg, tdq_cmd_if / tdq_rsp_if and tdq_task_ring.
//
// Usage: one command per transfer on cmd (submit, dispatch, complete, fetch);
// each command gives exactly one response transfer on rsp with a status code.
// cmd.ready is high only while the sequencer is idle; one command is in work
// at a time. rsp is a registered output, so the next command is taken while a
// response still waits for rsp.ready.
// Submit, complete and failed dispatch go through S_DONE to the response; a
// dispatch that pops the queue passes S_DISP (queue memory read) first. Fetch
// walks the result table through its single read port: S_FRD/S_FCMP for each
// entry searched, S_SHRD/S_SHWR for each entry moved up to close the gap. Each
// response load returns the sequencer to idle. When rsp stalls, the finished
// response waits in the sequencer until the output register frees; nothing is
// dropped. max_active is written through cfg_we/cfg_wdata; the user must write
// it only while idle; the block does not enforce it. Reset (synchronous)
// empties the queue and table, sets the next id to 1, clears the active count
// and loads max_active with 10. No clearing pass.
module task_dispatch_queue_with_result_table #(
  parameter int QUEUE_DEPTH  = 256,
  parameter int RESULT_DEPTH = 256,
  parameter int ID_WIDTH     = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  tdq_cmd_if.sink                   cmd,
  tdq_rsp_if.source                 rsp,
  input  logic                      cfg_we,
  input  logic [tdq_pkg::ACT_W-1:0] cfg_wdata
);
  import tdq_pkg::*;

  localparam int RA_W = (RESULT_DEPTH > 1) ? $clog2(RESULT_DEPTH) : 1;
  localparam int RF_W = $clog2(RESULT_DEPTH + 1);
  localparam int RW   = ID_WIDTH + REF_W;

  state_t state, state_next;

  // control state
  logic [ACT_W-1:0]    max_active;
  logic [ACT_W-1:0]    active;
  logic [ID_WIDTH-1:0] next_id;
  logic [RF_W-1:0]     res_fill;
  logic [RF_W-1:0]     ptr;
  logic                out_valid;

  // per-command working registers
  logic [ID_WIDTH-1:0] seek_id;
  status_t             p_status;
  logic [TID_W-1:0]    p_id;
  logic [REF_W-1:0]    p_f;
  logic [REF_W-1:0]    p_a;
  logic [REF_W-1:0]    p_v;

  // response register
  logic [STATUS_W-1:0] o_status;
  logic [TID_W-1:0]    o_id;
  logic [REF_W-1:0]    o_f;
  logic [REF_W-1:0]    o_a;
  logic [REF_W-1:0]    o_v;
  logic [ACT_W-1:0]    o_act;

  // result table
  logic [RW-1:0]   res_mem [RESULT_DEPTH];
  logic [RW-1:0]   res_rdata;
  logic [RW-1:0]   res_wdata;
  logic [RA_W-1:0] res_waddr;
  logic [RA_W-1:0] res_raddr;
  logic            res_we;
  logic            res_re;

  ring_ctrl_t          ring_ctrl;
  ring_stat_t          ring_stat;
  logic [REF_W-1:0]    ring_fref;
  logic [REF_W-1:0]    ring_aref;
  logic [ID_WIDTH-1:0] ring_id;

  logic [RF_W-1:0] ptr_inc;
  logic            res_full;
  logic            slot_free;
  logic            match;
  logic            out_load;

  assign ptr_inc   = ptr + RF_W'(1);
  assign res_full  = (res_fill == RF_W'(RESULT_DEPTH));
  assign slot_free = (active < max_active);
  assign match     = (res_rdata[RW-1 -: ID_WIDTH] == seek_id);

  tdq_task_ring #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ring_ctrl),
    .stat    (ring_stat),
    .wr_fref (cmd.function_ref),
    .wr_aref (cmd.argument_ref),
    .wr_id   (next_id),
    .rd_fref (ring_fref),
    .rd_aref (ring_aref),
    .rd_id   (ring_id)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd.ready      = (state == S_IDLE);
    ring_ctrl      = '0;
    res_we         = 1'b0;
    res_re         = 1'b0;
    res_waddr      = ptr[RA_W-1:0];
    res_raddr      = ptr[RA_W-1:0];
    res_wdata      = res_rdata;
    out_load       = 1'b0;
    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          case (cmd.command)
            CMD_SUBMIT: begin
              ring_ctrl.push = !ring_stat.full;
              state_next     = S_DONE;
            end
            CMD_DISPATCH: begin
              if (!ring_stat.empty && slot_free) begin
                ring_ctrl.pop = 1'b1;
                state_next    = S_DISP;
              end else begin
                state_next = S_DONE;
              end
            end
            CMD_COMPLETE: begin
              if (active != '0 && !res_full) begin
                res_we    = 1'b1;
                res_waddr = res_fill[RA_W-1:0];
                res_wdata = {ID_WIDTH'(cmd.task_id), cmd.result_value};
              end
              state_next = S_DONE;
            end
            default: state_next = S_FRD;
          endcase
        end
      end
      S_DISP: state_next = S_DONE;
      S_FRD: begin
        if (ptr < res_fill) begin
          res_re     = 1'b1;
          state_next = S_FCMP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FCMP: state_next = match ? S_SHRD : S_FRD;
      S_SHRD: begin
        if (ptr_inc < res_fill) begin
          res_re     = 1'b1;
          res_raddr  = ptr_inc[RA_W-1:0];
          state_next = S_SHWR;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SHWR: begin
        // entry behind the gap moves up one place
        res_we     = 1'b1;
        state_next = S_SHRD;
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      res_mem[res_waddr] <= res_wdata;
    end
    if (res_re) begin
      res_rdata <= res_mem[res_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_active <= MAX_ACTIVE_RESET;
      active     <= '0;
      next_id    <= ID_WIDTH'(1);
      res_fill   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_active <= cfg_wdata;
      end
      if (state == S_IDLE && cmd.valid) begin
        case (cmd.command)
          CMD_SUBMIT: begin
            if (!ring_stat.full) begin
              next_id <= next_id + ID_WIDTH'(1);
            end
          end
          CMD_DISPATCH: begin
            if (!ring_stat.empty && slot_free) begin
              active <= active + ACT_W'(1);
            end
          end
          CMD_COMPLETE: begin
            if (active != '0 && !res_full) begin
              active   <= active - ACT_W'(1);
              res_fill <= res_fill + RF_W'(1);
            end
          end
          default: ;
        endcase
      end
      if (state == S_SHRD && !(ptr_inc < res_fill)) begin
        res_fill <= res_fill - RF_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          seek_id  <= ID_WIDTH'(cmd.task_id);
          ptr      <= '0;
          p_id     <= '0;
          p_f      <= '0;
          p_a      <= '0;
          p_v      <= '0;
          p_status <= ST_OK;
          case (cmd.command)
            CMD_SUBMIT: begin
              if (ring_stat.full) begin
                p_status <= ST_QUEUE_FULL;
              end else begin
                p_id <= TID_W'(next_id);
              end
            end
            CMD_DISPATCH: begin
              if (ring_stat.empty) begin
                p_status <= ST_QUEUE_EMPTY;
              end else if (!slot_free) begin
                p_status <= ST_SLOTS_BUSY;
              end
            end
            CMD_COMPLETE: begin
              if (active == '0) begin
                p_status <= ST_NO_ACTIVE;
              end else if (res_full) begin
                p_status <= ST_RESULTS_FULL;
              end
            end
            default: ;
          endcase
        end
      end
      S_DISP: begin
        p_id <= TID_W'(ring_id);
        p_f  <= ring_fref;
        p_a  <= ring_aref;
      end
      S_FRD: begin
        if (!(ptr < res_fill)) begin
          p_status <= ST_NOT_FOUND;
        end
      end
      S_FCMP: begin
        if (match) begin
          p_v <= res_rdata[REF_W-1:0];
        end else begin
          ptr <= ptr_inc;
        end
      end
      S_SHWR: ptr <= ptr_inc;
      default: ;
    endcase
    if (out_load) begin
      o_status <= p_status;
      o_id     <= p_id;
      o_f      <= p_f;
      o_a      <= p_a;
      o_v      <= p_v;
      o_act    <= active;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.status           = o_status;
  assign rsp.out_task_id      = o_id;
  assign rsp.out_function_ref = o_f;
  assign rsp.out_argument_ref = o_a;
  assign rsp.out_result_value = o_v;
  assign rsp.active_now       = o_act;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for task_dispatch_queue_with_result_table: commands go in on
// tdq_cmd_if, every response on tdq_rsp_if is checked against an in-bench queue model.
// Depends on tdq_pkg, the tdq_cmd_if / tdq_rsp_if interfaces and the top-level design.

module testbench;
  import tdq_pkg::*;

  localparam int QUEUE_CAP   = 256;
  localparam int TABLE_CAP   = 256;
  localparam int QUIET_LIMIT = 6000;
  localparam int MAX_PRINTS  = 100;

  typedef struct {
    cmd_t             op;
    logic [REF_W-1:0] fn;
    logic [REF_W-1:0] arg;
    logic [TID_W-1:0] tid;
    logic [REF_W-1:0] val;
  } task_cmd_t;

  typedef struct {
    status_t          status;
    logic [TID_W-1:0] tid;
    logic [REF_W-1:0] fn;
    logic [REF_W-1:0] arg;
    logic [REF_W-1:0] val;
    logic [ACT_W-1:0] active;
  } reply_t;

  typedef struct {
    logic [REF_W-1:0] fn;
    logic [REF_W-1:0] arg;
    logic [TID_W-1:0] tid;
  } queued_task_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [ACT_W-1:0] cfg_wdata;

  tdq_cmd_if cmd_ch ();
  tdq_rsp_if rsp_ch ();

  task_dispatch_queue_with_result_table DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // expected state of the block
  queued_task_t     task_ring[$];
  logic [TID_W-1:0] tbl_ids[$];
  logic [REF_W-1:0] tbl_vals[$];
  logic [TID_W-1:0] running_ids[$];
  logic [TID_W-1:0] id_next    = TID_W'(1);
  logic [ACT_W-1:0] n_active   = '0;
  logic [ACT_W-1:0] active_cap = MAX_ACTIVE_RESET;

  task_cmd_t   pending[$];
  reply_t      replies_due[$];
  bit          cmd_fire, rsp_fire, calm;
  int unsigned send_wait, stall_left, quiet_cycles;
  int          errors, replies_seen, cap_writes;
  int          op_seen[4];
  int          status_seen[8];

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [REF_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic task_cmd_t mk(cmd_t op, logic [TID_W-1:0] tid, logic [REF_W-1:0] word);
    task_cmd_t c;
    c.op  = op;
    c.fn  = word;
    c.arg = word;
    c.tid = tid;
    c.val = word;
    return c;
  endfunction

  // Reply for one command; updates the expected state.
  function automatic reply_t predict_reply(task_cmd_t c);
    reply_t       r;
    queued_task_t t;
    int           hit;
    r.status = ST_OK;
    r.tid    = '0;
    r.fn     = '0;
    r.arg    = '0;
    r.val    = '0;
    hit      = -1;
    case (c.op)
      CMD_SUBMIT: begin
        if (task_ring.size() >= QUEUE_CAP) begin
          r.status = ST_QUEUE_FULL;
        end else begin
          t.fn  = c.fn;
          t.arg = c.arg;
          t.tid = id_next;
          task_ring.push_back(t);
          r.tid   = id_next;
          id_next = id_next + 1'b1;
        end
      end
      CMD_DISPATCH: begin
        // empty queue wins over the slot limit
        if (task_ring.size() == 0) begin
          r.status = ST_QUEUE_EMPTY;
        end else if (n_active >= active_cap) begin
          r.status = ST_SLOTS_BUSY;
        end else begin
          t = task_ring.pop_front();
          r.tid    = t.tid;
          r.fn     = t.fn;
          r.arg    = t.arg;
          n_active = n_active + 1'b1;
          running_ids.push_back(t.tid);
        end
      end
      CMD_COMPLETE: begin
        if (n_active == 0) begin
          r.status = ST_NO_ACTIVE;
        end else if (tbl_ids.size() >= TABLE_CAP) begin
          r.status = ST_RESULTS_FULL;
        end else begin
          tbl_ids.push_back(c.tid);
          tbl_vals.push_back(c.val);
          n_active = n_active - 1'b1;
          // any id is accepted; keep the running list the same length as n_active
          foreach (running_ids[i]) if (hit < 0 && running_ids[i] == c.tid) hit = i;
          running_ids.delete(hit < 0 ? 0 : hit);
        end
      end
      CMD_FETCH: begin
        foreach (tbl_ids[i]) if (hit < 0 && tbl_ids[i] == c.tid) hit = i;
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.val = tbl_vals[hit];
          tbl_ids.delete(hit);
          tbl_vals.delete(hit);
        end
      end
    endcase
    r.active = n_active;
    return r;
  endfunction

  // Mostly well-formed traffic: complete ids that are running, fetch ids that are stored.
  function automatic task_cmd_t random_cmd();
    task_cmd_t c;
    int        r;
    c.op  = cmd_t'($urandom_range(0, 3));
    c.fn  = rand_word();
    c.arg = rand_word();
    c.tid = TID_W'($urandom);
    c.val = rand_word();
    r     = $urandom_range(0, 99);
    if (r < 30) begin
      c.op = CMD_SUBMIT;
    end else if (r < 55) begin
      c.op = CMD_DISPATCH;
    end else if (r < 78) begin
      c.op = CMD_COMPLETE;
      if (running_ids.size() != 0 && $urandom_range(0, 9) != 0)
        c.tid = running_ids[$urandom_range(0, running_ids.size() - 1)];
    end else if (r < 95) begin
      c.op = CMD_FETCH;
      if (tbl_ids.size() != 0 && $urandom_range(0, 6) != 0)
        c.tid = tbl_ids[$urandom_range(0, tbl_ids.size() - 1)];
    end
    return c;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("mismatch %0d at response %0d: %s got %h expected %h",
               errors, replies_seen, what, got, want);
  endtask

  // Command driver: one transfer per item, random gap after each.
  always @(negedge clk) begin : cmd_driver
    task_cmd_t c;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_fire) begin
      if (send_wait != 0) begin
        cmd_ch.valid <= 1'b0;
        send_wait--;
      end else if (pending.size() != 0) begin
        c = pending.pop_front();
        cmd_ch.command      <= c.op;
        cmd_ch.function_ref <= c.fn;
        cmd_ch.argument_ref <= c.arg;
        cmd_ch.task_id      <= c.tid;
        cmd_ch.result_value <= c.val;
        cmd_ch.valid        <= 1'b1;
        send_wait = draw_wait();
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Response side back-pressure: ready drops for a random stretch after each transfer.
  always @(negedge clk) begin : rsp_driver
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_fire) stall_left = draw_wait();
      if (stall_left != 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : monitor
    task_cmd_t c;
    reply_t    want;
    cmd_fire = !rst && cmd_ch.valid && cmd_ch.ready;
    rsp_fire = !rst && rsp_ch.valid && rsp_ch.ready;
    if (!rst && cfg_we) begin
      active_cap = cfg_wdata;
      cap_writes++;
    end
    if (cmd_fire) begin
      c.op  = cmd_t'(cmd_ch.command);
      c.fn  = cmd_ch.function_ref;
      c.arg = cmd_ch.argument_ref;
      c.tid = cmd_ch.task_id;
      c.val = cmd_ch.result_value;
      replies_due.push_back(predict_reply(c));
      op_seen[int'(c.op)]++;
    end
    if (rsp_fire) begin
      replies_seen++;
      status_seen[rsp_ch.status]++;
      if (replies_due.size() == 0) begin
        report_mismatch("response with nothing pending, status", 32'(rsp_ch.status), '0);
      end else begin
        want = replies_due.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
        if (rsp_ch.out_task_id !== want.tid)
          report_mismatch("out_task_id", 32'(rsp_ch.out_task_id), 32'(want.tid));
        if (rsp_ch.out_function_ref !== want.fn)
          report_mismatch("out_function_ref", rsp_ch.out_function_ref, want.fn);
        if (rsp_ch.out_argument_ref !== want.arg)
          report_mismatch("out_argument_ref", rsp_ch.out_argument_ref, want.arg);
        if (rsp_ch.out_result_value !== want.val)
          report_mismatch("out_result_value", rsp_ch.out_result_value, want.val);
        if (rsp_ch.active_now !== want.active)
          report_mismatch("active_now", 32'(rsp_ch.active_now), 32'(want.active));
      end
    end
    if (cmd_fire || rsp_fire) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d responses outstanding",
               quiet_cycles, replies_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Wait until every queued command went through and its response came back.
  task automatic settle();
    while (pending.size() != 0 || cmd_ch.valid || replies_due.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_cap(input int v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ACT_W'(v);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic add_random(input int count);
    int n;
    n = 0;
    while (n < count) begin
      // keep the generator close to the model so picked ids are current
      while (pending.size() > 2) @(negedge clk);
      calm = ($urandom_range(0, 5) == 0);
      repeat (8) pending.push_back(random_cmd());
      n += 8;
    end
  endtask

  // Empty the result table: oldest entry first (exercises the gap close), rest newest first.
  task automatic drain_table();
    logic [TID_W-1:0] snap[$];
    settle();
    snap = tbl_ids;
    if (snap.size() != 0) begin
      pending.push_back(mk(CMD_FETCH, snap[0], $urandom));
      for (int i = snap.size() - 1; i > 0; i--)
        pending.push_back(mk(CMD_FETCH, snap[i], $urandom));
    end
    settle();
  endtask

  initial begin
    cmd_ch.valid        = 1'b0;
    cmd_ch.command      = CMD_SUBMIT;
    cmd_ch.function_ref = '0;
    cmd_ch.argument_ref = '0;
    cmd_ch.task_id      = '0;
    cmd_ch.result_value = '0;
    rsp_ch.ready        = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    rst                 = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: failure codes on an empty block, field extremes, duplicate ids
    pending.push_back(mk(CMD_DISPATCH, '0, $urandom));
    pending.push_back(mk(CMD_COMPLETE, '1, $urandom));
    pending.push_back(mk(CMD_FETCH, '0, $urandom));
    pending.push_back(mk(CMD_SUBMIT, '0, '0));
    pending.push_back(mk(CMD_SUBMIT, '1, '1));
    pending.push_back(mk(CMD_DISPATCH, '0, '0));
    pending.push_back(mk(CMD_DISPATCH, '1, '1));
    pending.push_back(mk(CMD_COMPLETE, '1, '1));
    pending.push_back(mk(CMD_COMPLETE, '0, '0));
    pending.push_back(mk(CMD_COMPLETE, 16'd9, $urandom));
    pending.push_back(mk(CMD_FETCH, '0, '1));
    pending.push_back(mk(CMD_FETCH, '1, '0));
    pending.push_back(mk(CMD_SUBMIT, 16'd7, $urandom));
    pending.push_back(mk(CMD_SUBMIT, 16'd7, $urandom));
    pending.push_back(mk(CMD_DISPATCH, 16'd7, $urandom));
    pending.push_back(mk(CMD_DISPATCH, 16'd7, $urandom));
    pending.push_back(mk(CMD_COMPLETE, 16'd7, 32'h1234_5678));
    pending.push_back(mk(CMD_COMPLETE, 16'd7, 32'h8765_4321));
    pending.push_back(mk(CMD_FETCH, 16'd7, $urandom));
    pending.push_back(mk(CMD_FETCH, 16'd7, $urandom));
    pending.push_back(mk(CMD_FETCH, 16'd7, $urandom));
    settle();

    // limit of zero: empty queue is reported first, then the limit blocks
    set_cap(0);
    pending.push_back(mk(CMD_DISPATCH, '0, $urandom));
    pending.push_back(mk(CMD_SUBMIT, '0, $urandom));
    pending.push_back(mk(CMD_DISPATCH, '0, $urandom));
    settle();

    set_cap(1);
    pending.push_back(mk(CMD_DISPATCH, '0, $urandom));
    pending.push_back(mk(CMD_SUBMIT, '0, $urandom));
    pending.push_back(mk(CMD_DISPATCH, '0, $urandom));
    pending.push_back(mk(CMD_COMPLETE, 16'd3, $urandom));
    pending.push_back(mk(CMD_DISPATCH, '0, $urandom));
    pending.push_back(mk(CMD_COMPLETE, 16'd4, $urandom));
    settle();

    // fill the task queue past its depth, then the result table past its depth
    set_cap(64);
    calm = 1'b0;
    repeat (QUEUE_CAP + 2) pending.push_back(mk(CMD_SUBMIT, TID_W'($urandom), rand_word()));
    settle();
    repeat (TABLE_CAP + 6) begin
      pending.push_back(mk(CMD_DISPATCH, TID_W'($urandom), rand_word()));
      pending.push_back(mk(CMD_COMPLETE, TID_W'($urandom), rand_word()));
    end
    drain_table();

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0, 5:    set_cap(64);
        1:       set_cap(1);
        2:       set_cap(2);
        6:       set_cap(10);
        default: set_cap($urandom_range(1, 64));
      endcase
      add_random(120);
    end

    settle();
    calm = 1'b0;
    repeat (20) @(negedge clk);

    $display("covered %0d submit, %0d dispatch, %0d complete, %0d fetch; %0d limit writes",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3], cap_writes);
    $display("statuses ok/qfull/qempty/busy/notfound/rfull/noactive %0d/%0d/%0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6]);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
